[design/vrp_pkg.sv]
// Shared constants, register codes and types of the vertex rotate/project block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package vrp_pkg;

  localparam int ANGLE_BITS_DEF = 12;
  localparam int COORD_BITS_DEF = 8;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register widths
  localparam int ANGLE_REG_W = 12;
  localparam int ZOOM_W      = 9;
  localparam int CENTER_W    = 11;
  localparam int DOFF_W      = 10;

  // result widths and limits
  localparam int SCR_W     = 12;
  localparam int DEPTH_W   = 9;
  localparam int SCR_MAX   = 2047;
  localparam int SCR_MIN   = -2048;
  localparam int DEPTH_MAX = 255;
  localparam int DEPTH_MIN = -256;

  // fixed point
  localparam int TRIG_W   = 16;      // signed Q1.14
  localparam int FRAC     = 14;
  localparam int ONE_Q14  = 16384;
  localparam int HALF_Q14 = 8192;
  localparam int ROT_GROW = 19;      // rotated coordinate width over the input width
  localparam int QUOT_W   = 14;      // quotient bits resolved by the divider

  // reset values
  localparam int ZOOM_RST     = 256;
  localparam int CENTER_X_RST = 250;
  localparam int CENTER_Y_RST = 200;
  localparam int DOFF_RST     = 220;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE_A  = 3'd0,
    REG_ANGLE_B  = 3'd1,
    REG_ANGLE_C  = 3'd2,
    REG_ZOOM     = 3'd3,
    REG_CENTER_X = 3'd4,
    REG_CENTER_Y = 3'd5,
    REG_DOFF     = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_a;
    logic signed [TRIG_W-1:0] cos_a;
    logic signed [TRIG_W-1:0] sin_b;
    logic signed [TRIG_W-1:0] cos_b;
    logic signed [TRIG_W-1:0] sin_c;
    logic signed [TRIG_W-1:0] cos_c;
  } trig_t;

endpackage

`default_nettype wire

[design/vrp_if.sv]
// Channel interfaces: vertex input, screen result and configuration write.
// Depends on vrp_pkg.
`default_nettype none

interface vrp_vert_if import vrp_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vert_x;
  logic signed [COORD_BITS-1:0] vert_y;
  logic signed [COORD_BITS-1:0] vert_z;

  modport source (output valid, output vert_x, output vert_y, output vert_z, input ready);
  modport sink   (input valid, input vert_x, input vert_y, input vert_z, output ready);
endinterface

interface vrp_screen_if import vrp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SCR_W-1:0]   screen_x;
  logic signed [SCR_W-1:0]   screen_y;
  logic signed [DEPTH_W-1:0] depth;
  logic                      clipped;

  modport source (output valid, output screen_x, output screen_y, output depth,
                  output clipped, input ready);
  modport sink   (input valid, input screen_x, input screen_y, input depth,
                  input clipped, output ready);
endinterface

interface vrp_cfg_if import vrp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[design/vrp_trig.sv]
// Sine/cosine unit: quarter-wave ROM built at elaboration, swept once per
// configuration write to refresh the six trig registers. Depends on vrp_pkg.
`default_nettype none

module vrp_trig import vrp_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [ANGLE_BITS-1:0] angle_a_i,
  input  logic [ANGLE_BITS-1:0] angle_b_i,
  input  logic [ANGLE_BITS-1:0] angle_c_i,
  output logic                  busy_o,
  output trig_t                 trig_o
);

  localparam int QB    = ANGLE_BITS - 2;
  localparam int QSIZE = 2 ** QB;
  localparam int IDX_W = ANGLE_BITS - 1;
  localparam int MAG_W = TRIG_W - 1;
  localparam logic [2:0] SEL_LAST = 3'd5;

  typedef logic [QSIZE:0][MAG_W-1:0] lut_t;

  // round(16384*sin) per entry, Taylor series in Q2.30
  function automatic lut_t gen_lut();
    lut_t        t;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] s;
    for (int i = 0; i <= QSIZE; i++) begin
      x    = (64'(i) * 64'd1686629713 + 64'(QSIZE / 2)) >> QB;
      x2   = (x * x) >> 30;
      term = x;
      s    = x;
      for (int k = 1; k <= 6; k++) begin
        term = (term * x2) >> 30;
        unique case (k)
          1:       term = term / 64'd6;
          2:       term = term / 64'd20;
          3:       term = term / 64'd42;
          4:       term = term / 64'd72;
          5:       term = term / 64'd110;
          default: term = term / 64'd156;
        endcase
        if ((k & 1) != 0) s = s - term;
        else              s = s + term;
      end
      t[i] = MAG_W'((s + 64'd32768) >> 16);
    end
    return t;
  endfunction

  localparam lut_t LUT = gen_lut();

  logic                     run_q;
  logic [2:0]               sel_q;
  logic                     wr_q;
  logic [2:0]               wsel_q;
  logic                     neg_q;
  logic [MAG_W-1:0]         rom_q;
  logic signed [TRIG_W-1:0] tab_q [6];

  logic [ANGLE_BITS-1:0] ang;
  logic [ANGLE_BITS-1:0] ph;
  logic [1:0]            quad;
  logic [QB-1:0]         r;
  logic [IDX_W-1:0]      idx;
  logic signed [TRIG_W-1:0] val;

  // even select: sine, odd select: cosine (quarter turn ahead)
  always_comb begin
    unique case (sel_q[2:1])
      2'd0:    ang = angle_a_i;
      2'd1:    ang = angle_b_i;
      default: ang = angle_c_i;
    endcase
    ph   = ang + (sel_q[0] ? ANGLE_BITS'(QSIZE) : '0);
    quad = ph[ANGLE_BITS-1 -: 2];
    r    = ph[QB-1:0];
    idx  = quad[0] ? (IDX_W'(QSIZE) - IDX_W'(r)) : IDX_W'(r);
    val  = signed'({1'b0, rom_q});
  end

  always_ff @(posedge clk_i) begin
    if (run_q) begin
      rom_q <= LUT[idx];
      neg_q <= quad[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      sel_q  <= '0;
      wr_q   <= 1'b0;
      wsel_q <= '0;
      for (int i = 0; i < 6; i++) begin
        tab_q[i] <= ((i & 1) != 0) ? TRIG_W'(ONE_Q14) : '0;
      end
    end else begin
      wr_q   <= run_q;
      wsel_q <= sel_q;
      if (start_i) begin
        run_q <= 1'b1;
        sel_q <= '0;
      end else if (run_q) begin
        sel_q <= sel_q + 3'd1;
        if (sel_q == SEL_LAST) run_q <= 1'b0;
      end
      if (wr_q) tab_q[wsel_q] <= neg_q ? -val : val;
    end
  end

  assign busy_o = run_q | wr_q;
  assign trig_o = '{sin_a: tab_q[0], cos_a: tab_q[1], sin_b: tab_q[2],
                    cos_b: tab_q[3], sin_c: tab_q[4], cos_c: tab_q[5]};

endmodule

`default_nettype wire

[design/vrp_rotate.sv]
// Six-stage rotation pipeline: xy, then yz, then zx plane, Q1.14 products
// rounded to nearest, ties away from zero. Depends on vrp_pkg.
`default_nettype none

module vrp_rotate import vrp_pkg::*; #(
  parameter  int COORD_BITS = COORD_BITS_DEF,
  localparam int ROT_W      = COORD_BITS + ROT_GROW
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] vert_x_i,
  input  logic signed [COORD_BITS-1:0] vert_y_i,
  input  logic signed [COORD_BITS-1:0] vert_z_i,
  input  trig_t                        trig_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [ROT_W-1:0]      tx2_o,
  output logic signed [ROT_W-1:0]      ty2_o,
  output logic signed [ROT_W-1:0]      tz2_o
);

  localparam int C    = COORD_BITS;
  localparam int TX_W = C + 16;
  localparam int PW   = C + 31;
  localparam int R1_W = C + 17;
  localparam int W2   = C + 33;
  localparam int NS   = 6;

  function automatic logic signed [W2-1:0] rnd14(input logic signed [W2-1:0] v);
    logic [W2-1:0] mag;
    logic [W2-1:0] r;
    mag = v[W2-1] ? -v : v;
    r   = (mag + W2'(HALF_Q14)) >> FRAC;
    return v[W2-1] ? -signed'(r) : signed'(r);
  endfunction

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) en[k] = !v_q[k] || en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];

  logic signed [C-1:0]     vx_q, vy_q, vz_q, vz1_q;
  logic signed [TX_W-1:0]  tx1_q, ty1_q, tx2s_q, tx3_q;
  logic signed [PW-1:0]    p1_q, p2_q, p3_q, p4_q;
  logic signed [R1_W-1:0]  ty2_q, tz_q, ty2b_q;
  logic signed [W2-1:0]    m1_q, m2_q, m3_q, m4_q;
  logic signed [ROT_W-1:0] tx2_q, ty2o_q, tz2_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      vx_q <= vert_x_i;
      vy_q <= vert_y_i;
      vz_q <= vert_z_i;
    end
    if (en[1]) begin
      tx1_q <= TX_W'(vx_q) * TX_W'(trig_i.cos_a) - TX_W'(vy_q) * TX_W'(trig_i.sin_a);
      ty1_q <= TX_W'(vx_q) * TX_W'(trig_i.sin_a) + TX_W'(vy_q) * TX_W'(trig_i.cos_a);
      vz1_q <= vz_q;
    end
    if (en[2]) begin
      p1_q   <= PW'(vz1_q) * PW'(trig_i.sin_b);
      p2_q   <= PW'(ty1_q) * PW'(trig_i.cos_b);
      p3_q   <= PW'(ty1_q) * PW'(trig_i.sin_b);
      p4_q   <= PW'(vz1_q) * PW'(trig_i.cos_b);
      tx2s_q <= tx1_q;
    end
    if (en[3]) begin
      ty2_q <= R1_W'(rnd14((W2'(p1_q) <<< FRAC) - W2'(p2_q)));
      tz_q  <= R1_W'(rnd14(W2'(p3_q) + (W2'(p4_q) <<< FRAC)));
      tx3_q <= tx2s_q;
    end
    if (en[4]) begin
      m1_q   <= W2'(tz_q) * W2'(trig_i.cos_c);
      m2_q   <= W2'(tx3_q) * W2'(trig_i.sin_c);
      m3_q   <= W2'(tz_q) * W2'(trig_i.sin_c);
      m4_q   <= W2'(tx3_q) * W2'(trig_i.cos_c);
      ty2b_q <= ty2_q;
    end
    if (en[5]) begin
      tz2_q  <= ROT_W'(rnd14(m1_q - m2_q));
      tx2_q  <= ROT_W'(rnd14(m3_q + m4_q));
      ty2o_q <= ROT_W'(ty2b_q);
    end
  end

  assign tx2_o = tx2_q;
  assign ty2_o = ty2o_q;
  assign tz2_o = tz2_q;

endmodule

`default_nettype wire

[design/vrp_project.sv]
// Projection pipeline: zoom multiply, divisor, pipelined restoring divider
// (two quotient bits per stage), centre add and saturation. Depends on vrp_pkg.
`default_nettype none

module vrp_project import vrp_pkg::*; #(
  parameter  int COORD_BITS = COORD_BITS_DEF,
  localparam int ROT_W      = COORD_BITS + ROT_GROW
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [ROT_W-1:0]    tx2_i,
  input  logic signed [ROT_W-1:0]    ty2_i,
  input  logic signed [ROT_W-1:0]    tz2_i,
  input  logic [ZOOM_W-1:0]          zoom_i,
  input  logic signed [CENTER_W-1:0] center_x_i,
  input  logic signed [CENTER_W-1:0] center_y_i,
  input  logic [DOFF_W-1:0]          depth_offset_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SCR_W-1:0]    screen_x_o,
  output logic signed [SCR_W-1:0]    screen_y_o,
  output logic signed [DEPTH_W-1:0]  depth_o,
  output logic                       clipped_o
);

  localparam int NUM_W = ROT_W + ZOOM_W + 1;
  localparam int DEN_W = ROT_W + 1;
  localparam int QW    = QUOT_W;
  localparam int DS    = QW / 2;
  localparam int REM_W = DEN_W + QW;
  localparam int SUM_W = QW + 2;
  localparam int NS    = DS + 3;

  typedef struct packed {
    logic                      den_pos;
    logic                      neg_x;
    logic                      nz_x;
    logic                      ovf_x;
    logic                      neg_y;
    logic                      nz_y;
    logic                      ovf_y;
    logic signed [DEPTH_W-1:0] depth;
    logic                      dclip;
  } side_t;

  typedef struct packed {
    logic signed [SCR_W-1:0] v;
    logic                    clip;
  } scr_t;

  function automatic scr_t finish(input logic den_pos, input logic neg, input logic nz,
                                  input logic ovf, input logic [QW-1:0] q,
                                  input logic signed [CENTER_W-1:0] ctr);
    scr_t                    res;
    logic signed [SUM_W-1:0] qs;
    logic signed [SUM_W-1:0] sum;
    qs       = neg ? -signed'(SUM_W'(q)) : signed'(SUM_W'(q));
    sum      = qs + SUM_W'(ctr);
    res.clip = 1'b1;
    priority if (!den_pos) begin
      // divisor not positive: saturate toward the numerator's sign
      if (neg)     res.v = SCR_W'(SCR_MIN);
      else if (nz) res.v = SCR_W'(SCR_MAX);
      else         res.v = SCR_W'(ctr);
    end else if (ovf) begin
      res.v = neg ? SCR_W'(SCR_MIN) : SCR_W'(SCR_MAX);
    end else if (sum > SCR_MAX) begin
      res.v = SCR_W'(SCR_MAX);
    end else if (sum < SCR_MIN) begin
      res.v = SCR_W'(SCR_MIN);
    end else begin
      res.v    = SCR_W'(sum);
      res.clip = 1'b0;
    end
    return res;
  endfunction

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) en[k] = !v_q[k] || en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];

  // stage 0: numerators, divisor, depth
  logic signed [NUM_W-1:0]   numx_q, numy_q;
  logic signed [DEN_W-1:0]   den_q;
  logic signed [DEPTH_W-1:0] dep_q;
  logic                      dclip_q;
  logic [ROT_W-1:0]          tmag;
  logic signed [ROT_W-1:0]   dq;
  logic signed [DEPTH_W-1:0] dep_d;
  logic                      dclip_d;

  always_comb begin
    tmag    = tz2_i[ROT_W-1] ? -tz2_i : tz2_i;
    dq      = tz2_i[ROT_W-1] ? -signed'(tmag >> FRAC) : signed'(tmag >> FRAC);
    dclip_d = 1'b1;
    priority if (dq > DEPTH_MAX) begin
      dep_d = DEPTH_W'(DEPTH_MAX);
    end else if (dq < DEPTH_MIN) begin
      dep_d = DEPTH_W'(DEPTH_MIN);
    end else begin
      dep_d   = DEPTH_W'(dq);
      dclip_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      numx_q  <= NUM_W'(tx2_i) * NUM_W'(signed'({1'b0, zoom_i}));
      numy_q  <= NUM_W'(ty2_i) * NUM_W'(signed'({1'b0, zoom_i}));
      den_q   <= DEN_W'(tz2_i) + (DEN_W'(signed'({1'b0, depth_offset_i})) <<< FRAC);
      dep_q   <= dep_d;
      dclip_q <= dclip_d;
    end
  end

  // stage 1 fills slot 0; divider stage j moves slot j to slot j+1
  logic [REM_W-1:0] remx_q [DS+1];
  logic [REM_W-1:0] remy_q [DS+1];
  logic [QW-1:0]    qx_q   [DS+1];
  logic [QW-1:0]    qy_q   [DS+1];
  logic [DEN_W-1:0] dmag_q [DS+1];
  side_t            side_q [DS+1];

  logic [NUM_W-1:0] nmagx, nmagy;
  side_t            side_d;

  always_comb begin
    nmagx          = numx_q[NUM_W-1] ? -numx_q : numx_q;
    nmagy          = numy_q[NUM_W-1] ? -numy_q : numy_q;
    side_d.den_pos = !den_q[DEN_W-1] && (den_q != '0);
    side_d.neg_x   = numx_q[NUM_W-1];
    side_d.nz_x    = numx_q != '0;
    side_d.ovf_x   = REM_W'(nmagx) >= (REM_W'(den_q) << QW);
    side_d.neg_y   = numy_q[NUM_W-1];
    side_d.nz_y    = numy_q != '0;
    side_d.ovf_y   = REM_W'(nmagy) >= (REM_W'(den_q) << QW);
    side_d.depth   = dep_q;
    side_d.dclip   = dclip_q;
  end

  logic [REM_W-1:0] rx_d [DS];
  logic [REM_W-1:0] ry_d [DS];
  logic [QW-1:0]    qx_d [DS];
  logic [QW-1:0]    qy_d [DS];

  always_comb begin
    for (int j = 0; j < DS; j++) begin
      rx_d[j] = remx_q[j];
      ry_d[j] = remy_q[j];
      qx_d[j] = qx_q[j];
      qy_d[j] = qy_q[j];
      for (int b = 0; b < 2; b++) begin
        if (rx_d[j] >= (REM_W'(dmag_q[j]) << (QW - 1 - 2 * j - b))) begin
          rx_d[j] = rx_d[j] - (REM_W'(dmag_q[j]) << (QW - 1 - 2 * j - b));
          qx_d[j][QW-1-2*j-b] = 1'b1;
        end
        if (ry_d[j] >= (REM_W'(dmag_q[j]) << (QW - 1 - 2 * j - b))) begin
          ry_d[j] = ry_d[j] - (REM_W'(dmag_q[j]) << (QW - 1 - 2 * j - b));
          qy_d[j][QW-1-2*j-b] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      remx_q[0] <= REM_W'(nmagx);
      remy_q[0] <= REM_W'(nmagy);
      qx_q[0]   <= '0;
      qy_q[0]   <= '0;
      dmag_q[0] <= den_q;
      side_q[0] <= side_d;
    end
    for (int j = 0; j < DS; j++) begin
      if (en[j+2]) begin
        remx_q[j+1] <= rx_d[j];
        remy_q[j+1] <= ry_d[j];
        qx_q[j+1]   <= qx_d[j];
        qy_q[j+1]   <= qy_d[j];
        dmag_q[j+1] <= dmag_q[j];
        side_q[j+1] <= side_q[j];
      end
    end
  end

  // final stage doubles as the output register
  scr_t                      fx, fy;
  logic signed [SCR_W-1:0]   sx_q, sy_q;
  logic signed [DEPTH_W-1:0] dz_q;
  logic                      clip_q;

  always_comb begin
    fx = finish(side_q[DS].den_pos, side_q[DS].neg_x, side_q[DS].nz_x, side_q[DS].ovf_x,
                qx_q[DS], center_x_i);
    fy = finish(side_q[DS].den_pos, side_q[DS].neg_y, side_q[DS].nz_y, side_q[DS].ovf_y,
                qy_q[DS], center_y_i);
  end

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      sx_q   <= fx.v;
      sy_q   <= fy.v;
      dz_q   <= side_q[DS].depth;
      clip_q <= fx.clip | fy.clip | side_q[DS].dclip;
    end
  end

  assign screen_x_o = sx_q;
  assign screen_y_o = sy_q;
  assign depth_o    = dz_q;
  assign clipped_o  = clip_q;

endmodule

`default_nettype wire

[design/vertex_rotate_project_top.sv]
// Top level: configuration registers, trig refresh, rotation and projection.
// Depends on vrp_pkg, vrp_if, vrp_trig, vrp_rotate, vrp_project.
//
//   channel   dir  handshake      payload
//   cfg_i     in   valid/ready    index, data (register write)
//   vert_i    in   valid/ready    vert_x, vert_y, vert_z
//   screen_o  out  valid/ready    screen_x, screen_y, depth, clipped
//
// One vertex per cycle while no trig sweep runs and screen_o is not stalled;
// 6 rotation, 10 projection stages, two quotient bits per divider stage.
// A configuration write re-reads the sine ROM for all six sin/cos values; vert_i
// is held off while that sweep runs. Reset gives angle 0 directly.
// Every stage holds its transaction while downstream stalls; bubbles collapse.
`default_nettype none

module vertex_rotate_project_top import vrp_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  vrp_cfg_if.sink       cfg_i,
  vrp_vert_if.sink      vert_i,
  vrp_screen_if.source  screen_o
);

  localparam int ROT_W = COORD_BITS + ROT_GROW;

  logic [ANGLE_BITS-1:0]      angle_a_q, angle_b_q, angle_c_q;
  logic [ZOOM_W-1:0]          zoom_q;
  logic signed [CENTER_W-1:0] center_x_q, center_y_q;
  logic [DOFF_W-1:0]          doff_q;
  logic                       cfg_we;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_a_q  <= '0;
      angle_b_q  <= '0;
      angle_c_q  <= '0;
      zoom_q     <= ZOOM_W'(ZOOM_RST);
      center_x_q <= CENTER_W'(CENTER_X_RST);
      center_y_q <= CENTER_W'(CENTER_Y_RST);
      doff_q     <= DOFF_W'(DOFF_RST);
    end else if (cfg_we) begin
      unique case (cfg_i.index)
        REG_ANGLE_A:  angle_a_q  <= ANGLE_BITS'(cfg_i.data[ANGLE_REG_W-1:0]);
        REG_ANGLE_B:  angle_b_q  <= ANGLE_BITS'(cfg_i.data[ANGLE_REG_W-1:0]);
        REG_ANGLE_C:  angle_c_q  <= ANGLE_BITS'(cfg_i.data[ANGLE_REG_W-1:0]);
        REG_ZOOM:     zoom_q     <= cfg_i.data[ZOOM_W-1:0];
        REG_CENTER_X: center_x_q <= signed'(cfg_i.data[CENTER_W-1:0]);
        REG_CENTER_Y: center_y_q <= signed'(cfg_i.data[CENTER_W-1:0]);
        REG_DOFF:     doff_q     <= cfg_i.data[DOFF_W-1:0];
        default: ;
      endcase
    end
  end

  trig_t trig;
  logic  trig_busy;

  vrp_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cfg_we),
    .angle_a_i (angle_a_q),
    .angle_b_i (angle_b_q),
    .angle_c_i (angle_c_q),
    .busy_o    (trig_busy),
    .trig_o    (trig)
  );

  logic                    rot_ready;
  logic                    rot_valid;
  logic                    prj_ready;
  logic signed [ROT_W-1:0] tx2, ty2, tz2;

  assign vert_i.ready = rot_ready & !trig_busy;

  vrp_rotate #(.COORD_BITS(COORD_BITS)) u_rotate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vert_i.valid & !trig_busy),
    .in_ready_o  (rot_ready),
    .vert_x_i    (vert_i.vert_x),
    .vert_y_i    (vert_i.vert_y),
    .vert_z_i    (vert_i.vert_z),
    .trig_i      (trig),
    .out_valid_o (rot_valid),
    .out_ready_i (prj_ready),
    .tx2_o       (tx2),
    .ty2_o       (ty2),
    .tz2_o       (tz2)
  );

  vrp_project #(.COORD_BITS(COORD_BITS)) u_project (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (rot_valid),
    .in_ready_o     (prj_ready),
    .tx2_i          (tx2),
    .ty2_i          (ty2),
    .tz2_i          (tz2),
    .zoom_i         (zoom_q),
    .center_x_i     (center_x_q),
    .center_y_i     (center_y_q),
    .depth_offset_i (doff_q),
    .out_valid_o    (screen_o.valid),
    .out_ready_i    (screen_o.ready),
    .screen_x_o     (screen_o.screen_x),
    .screen_y_o     (screen_o.screen_y),
    .depth_o        (screen_o.depth),
    .clipped_o      (screen_o.clipped)
  );

endmodule

`default_nettype wire
